// File: src/srtf_pkg.sv
package srtf_pkg;

    localparam int MAX_PROCS = 16;
    localparam int SLOT_W    = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int SCAN_W    = $clog2(MAX_PROCS + 1);

    localparam int SLOT_IN_W = 4;
    localparam int ARR_W     = 15;
    localparam int BURST_W   = 12;
    localparam int TIME_W    = 17;
    localparam int CNT_W     = 5;

    localparam int S_DATA_W  = 32;
    localparam int M_DATA_W  = 80;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    localparam logic [PADDR_W-1:0] ADDR_PROCESS_COUNT = PADDR_W'(0);
    localparam logic [CNT_W-1:0]   PROCESS_COUNT_RST  = CNT_W'(1);
    localparam logic [CNT_W-1:0]   DONE_MAX           = CNT_W'(31);

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // best candidate handed along the chain
    typedef struct packed {
        logic               valid;
        logic [SLOT_W-1:0]  slot;
        logic [BURST_W-1:0] rem;
        logic [ARR_W-1:0]   arrival;
        logic [BURST_W-1:0] burst;
        logic               started;
    } cand_t;

    // write command broadcast to all cells
    typedef struct packed {
        logic               load;
        logic               tick;
        logic [SLOT_W-1:0]  slot;
        logic [ARR_W-1:0]   arrival;
        logic [BURST_W-1:0] burst;
    } upd_t;

endpackage

// File: src/srtf_cell.sv
module srtf_cell
    import srtf_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [SLOT_W-1:0] idx,
    input  logic [CNT_W-1:0]  count,
    input  logic [TIME_W-1:0] now,
    input  upd_t              upd,
    input  cand_t             best_in,
    output cand_t             best_out
);

    logic [ARR_W-1:0]   arrival_reg, arrival_next;
    logic [BURST_W-1:0] burst_reg, burst_next;
    logic [BURST_W-1:0] rem_reg, rem_next;
    logic               started_reg, started_next;
    cand_t              best_reg, best_next;
    logic               hit, eligible, take;

    assign hit = (upd.slot == idx);

    always_comb begin
        arrival_next = arrival_reg;
        burst_next   = burst_reg;
        rem_next     = rem_reg;
        started_next = started_reg;
        if (upd.load && hit) begin
            arrival_next = upd.arrival;
            burst_next   = upd.burst;
            rem_next     = upd.burst;
            started_next = 1'b0;
        end else if (upd.tick && hit) begin
            rem_next     = rem_reg - BURST_W'(1);
            started_next = 1'b1;
        end
    end

    // strict less-than keeps the lower slot on a tie
    assign eligible = (32'(idx) < 32'(count)) && (TIME_W'(arrival_reg) <= now)
                      && (rem_reg != '0);
    assign take = eligible && (!best_in.valid || (rem_reg < best_in.rem));

    always_comb begin
        if (take) begin
            best_next.valid   = 1'b1;
            best_next.slot    = idx;
            best_next.rem     = rem_reg;
            best_next.arrival = arrival_reg;
            best_next.burst   = burst_reg;
            best_next.started = started_reg;
        end else begin
            best_next = best_in;
        end
    end

    always_ff @(posedge aclk) begin
        arrival_reg <= arrival_next;
        burst_reg   <= burst_next;
        rem_reg     <= rem_next;
        best_reg    <= best_next;
        if (!aresetn) begin
            started_reg <= 1'b0;
        end else begin
            started_reg <= started_next;
        end
    end

    assign best_out = best_reg;

endmodule

// File: src/srtf_chain.sv
module srtf_chain
    import srtf_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [CNT_W-1:0]  count,
    input  logic [TIME_W-1:0] now,
    input  upd_t              upd,
    output cand_t             best
);

    cand_t links [MAX_PROCS+1];

    assign links[0] = '0;

    for (genvar i = 0; i < MAX_PROCS; i++) begin : g_cell
        srtf_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .idx      (SLOT_W'(i)),
            .count    (count),
            .now      (now),
            .upd      (upd),
            .best_in  (links[i]),
            .best_out (links[i+1])
        );
    end

    assign best = links[MAX_PROCS];

endmodule

// File: src/shortest_remaining_time_scheduler_unit.sv
// Shortest-remaining-time-first scheduler, one time unit per tick item.
// Input stream (s_*): s_tuser is the item kind, 0 = load, 1 = tick. A load
// writes one slot's arrival and burst and gives no result; a tick runs the
// slot with the least remaining time (lowest slot on a tie) for one unit.
// Result stream (m_*): one item per tick with the tick time, runner, switch
// flag, response time on first start and turnaround/waiting on completion.
// APB port: process_count at address 0, written only while the block is idle;
// the user must keep to this, as the block does not check it. Slots sit in a
// row of cells; the best candidate moves one cell per cycle, so a tick scans
// the whole row and then issues; s_tready stays low until the tick has issued.
// The result sits in an output register; a stalled m_tready holds it there
// and the next tick waits in its issue cycle until the register is free.
// Reset (aresetn low, synchronous) clears time, started flags, done count,
// last runner and sets process_count to 1; slot data is undefined until
// loaded.
module shortest_remaining_time_scheduler_unit
    import srtf_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,  // slot[3:0], arrival[18:4], burst[30:19]
    input  logic                s_tuser,  // kind
    output logic                m_tvalid,
    input  logic                m_tready,
    // tick_time[16:0], idle[17], running_slot[21:18], switched[22], first_start[23],
    // response_time[40:24], finished[41], turnaround[58:42], waiting[75:59],
    // all_done[76]
    output logic [M_DATA_W-1:0] m_tdata,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready
);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_EMIT} state_t;
    typedef enum logic [1:0] {RUN_NONE, RUN_IDLE, RUN_SLOT} runner_t;

    state_t              state_reg;
    logic [SCAN_W-1:0]   scan_reg;
    logic [CNT_W-1:0]    pcount_reg;
    logic [TIME_W-1:0]   time_reg;
    runner_t             last_kind_reg;
    logic [SLOT_W-1:0]   last_slot_reg;
    logic [CNT_W-1:0]    done_reg;
    logic                m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;

    logic [SLOT_IN_W-1:0] in_slot;
    logic [ARR_W-1:0]     in_arrival;
    logic [BURST_W-1:0]   in_burst;
    logic                 s_fire, out_free, issue, all_done_now;
    logic [CNT_W-1:0]     active, done_next;
    cand_t                best;
    upd_t                 upd;

    logic                 switched, first_start, finished, all_done_after;
    logic [TIME_W-1:0]    t_plus, response, turnaround, waiting;
    logic [M_DATA_W-1:0]  m_tdata_next;

    assign in_slot    = s_tdata[3:0];
    assign in_arrival = s_tdata[18:4];
    assign in_burst   = s_tdata[30:19];

    assign s_tready = (state_reg == S_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign issue    = (state_reg == S_EMIT) && out_free;

    assign active = (32'(pcount_reg) > MAX_PROCS) ? CNT_W'(MAX_PROCS) : pcount_reg;
    assign all_done_now = (done_reg >= active);

    assign upd.load    = s_fire && (s_tuser == KIND_LOAD) && (32'(in_slot) < MAX_PROCS);
    assign upd.tick    = issue && !all_done_now && best.valid;
    assign upd.slot    = upd.load ? SLOT_W'(in_slot) : best.slot;
    assign upd.arrival = in_arrival;
    assign upd.burst   = in_burst;

    srtf_chain u_chain (
        .aclk    (aclk),
        .aresetn (aresetn),
        .count   (pcount_reg),
        .now     (time_reg),
        .upd     (upd),
        .best    (best)
    );

    assign t_plus      = time_reg + TIME_W'(1);
    assign first_start = best.valid && !best.started;
    assign finished    = best.valid && (best.rem == BURST_W'(1));
    assign response    = first_start ? (time_reg - TIME_W'(best.arrival)) : '0;
    assign turnaround  = finished ? (t_plus - TIME_W'(best.arrival)) : '0;
    assign waiting     = finished ? (turnaround - TIME_W'(best.burst)) : '0;
    assign done_next   = (finished && done_reg < DONE_MAX) ? done_reg + CNT_W'(1) : done_reg;
    assign all_done_after = (done_next >= active);

    always_comb begin
        if (best.valid) begin
            switched = !(last_kind_reg == RUN_SLOT && last_slot_reg == best.slot);
        end else begin
            switched = (last_kind_reg != RUN_IDLE);
        end
    end

    always_comb begin
        m_tdata_next = '0;
        m_tdata_next[16:0] = time_reg;
        if (all_done_now) begin
            m_tdata_next[17] = 1'b1;
            m_tdata_next[76] = 1'b1;
        end else begin
            m_tdata_next[17]    = !best.valid;
            m_tdata_next[21:18] = best.valid ? SLOT_IN_W'(best.slot) : '0;
            m_tdata_next[22]    = switched;
            m_tdata_next[23]    = first_start;
            m_tdata_next[40:24] = response;
            m_tdata_next[41]    = finished;
            m_tdata_next[58:42] = turnaround;
            m_tdata_next[75:59] = waiting;
            m_tdata_next[76]    = all_done_after;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            scan_reg      <= '0;
            pcount_reg    <= PROCESS_COUNT_RST;
            time_reg      <= '0;
            last_kind_reg <= RUN_NONE;
            last_slot_reg <= '0;
            done_reg      <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (psel && penable && pwrite && paddr == ADDR_PROCESS_COUNT) begin
                pcount_reg <= pwdata[CNT_W-1:0];
            end
            if (m_tvalid_reg && m_tready && !issue) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_fire && s_tuser == KIND_TICK) begin
                        state_reg <= S_SCAN;
                        scan_reg  <= '0;
                    end
                end
                S_SCAN: begin
                    // wait until the candidate has crossed every cell
                    if (scan_reg == SCAN_W'(MAX_PROCS - 1)) begin
                        state_reg <= S_EMIT;
                    end else begin
                        scan_reg <= scan_reg + SCAN_W'(1);
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= m_tdata_next;
                        state_reg    <= S_IDLE;
                        if (!all_done_now) begin
                            time_reg <= t_plus;
                            done_reg <= done_next;
                            if (best.valid) begin
                                last_kind_reg <= RUN_SLOT;
                                last_slot_reg <= best.slot;
                            end else begin
                                last_kind_reg <= RUN_IDLE;
                            end
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign pready   = 1'b1;
    assign prdata   = (paddr == ADDR_PROCESS_COUNT) ? PDATA_W'(pcount_reg) : '0;

endmodule
